[rtl/core/slr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_pkg: shared types and constants
// Widths, fixed-point constants, cfg indices, sequencer and divider types.
// ----------------------------------------------------------------------------
package slr_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int RATIO_BITS  = 20;
    localparam int GAIN_BITS   = 17;
    localparam int PHASE_BITS  = 26;
    localparam int STEP_BITS   = 25;
    localparam int MAX_OUT     = 8;
    localparam int CNT_BITS    = 4;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 20;

    localparam logic [RATIO_BITS-1:0] ONE_Q     = RATIO_BITS'(1) << FRAC_BITS;
    localparam logic [RATIO_BITS-1:0] RATIO_MIN = ONE_Q >> 8;
    localparam logic [RATIO_BITS-1:0] RATIO_MAX = RATIO_BITS'(ONE_Q << 3);

    localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_RATIO = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SMOOTH_GAIN  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT,
        ST_WAIT_OUT,
        ST_DIV,
        ST_FINISH
    } slr_state_t;

    // Divider control and status.
    typedef struct packed {
        logic                  start;
        logic [RATIO_BITS-1:0] divisor;
    } slr_div_ctrl_t;

    typedef struct packed {
        logic                 done;
        logic [STEP_BITS-1:0] quotient;
    } slr_div_stat_t;

endpackage

[rtl/core/slr_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_divider: restoring divider
// Computes ONE*ONE / divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module slr_divider
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  slr_pkg::slr_div_ctrl_t ctrl,
    output slr_pkg::slr_div_stat_t stat
);
    import slr_pkg::*;

    localparam int DIVIDEND_BITS = 2 * FRAC_BITS + 1;
    localparam int BIT_CNT_BITS  = $clog2(DIVIDEND_BITS + 1);

    logic [RATIO_BITS:0]          rem_reg, rem_next;
    logic [DIVIDEND_BITS-1:0]     quo_reg, quo_next;
    logic [RATIO_BITS-1:0]        dvs_reg, dvs_next;
    logic [BIT_CNT_BITS-1:0]      cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [RATIO_BITS:0]          trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[RATIO_BITS-1:0], quo_reg[DIVIDEND_BITS-1]};
        if (ctrl.start)
        begin
            rem_next  = '0;
            quo_next  = DIVIDEND_BITS'(1) << (2 * FRAC_BITS);
            dvs_next  = ctrl.divisor;
            cnt_next  = BIT_CNT_BITS'(DIVIDEND_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[DIVIDEND_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[DIVIDEND_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == BIT_CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    // Divisor is at least ONE/256, so the quotient fits in STEP_BITS.
    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg[STEP_BITS-1:0];

endmodule

[rtl/core/stereo_linear_resampler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_linear_resampler: linear-interpolation sample rate converter
// Stereo Q1.15 frames in, interpolated stereo frames out at a smoothed ratio.
// ----------------------------------------------------------------------------
// Each accepted input transaction carries one stereo frame. The first frame
// after reset only primes the history and produces nothing. Every later frame
// produces between zero and eight output transactions, the last of which has
// tlast set. Each output is interpolated into a staging register, then a
// restoring division (one quotient bit per cycle) turns the smoothed ratio
// into the phase step, and then the output waits for the output register to
// drain. An input frame occupies the block until its outputs are done, and
// s_tready is low meanwhile. Configuration writes are accepted at any time
// but should be made only while idle.
// ----------------------------------------------------------------------------
module stereo_linear_resampler
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // right_in (upper), left_in (lower)
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,   // right_out (upper), left_out (lower)
    output logic                              m_tlast,   // last_of_run
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [slr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [slr_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import slr_pkg::*;

    localparam int PROD_BITS = SAMPLE_BITS + 1 + FRAC_BITS + 1;
    localparam int DIFF_BITS = RATIO_BITS + GAIN_BITS;

    slr_state_t state_reg, state_next;

    logic signed [SAMPLE_BITS-1:0] prev_l_reg, prev_r_reg, cur_l_reg, cur_r_reg;
    logic [PHASE_BITS-1:0]         phase_reg, phase_next;
    logic [RATIO_BITS-1:0]         ratio_reg, ratio_next;
    logic                          primed_reg;
    logic [RATIO_BITS-1:0]         target_reg;
    logic [GAIN_BITS-1:0]          gain_reg;
    logic [CNT_BITS-1:0]           cnt_reg;
    logic                          out_valid_reg;
    logic [2*SAMPLE_BITS-1:0]      out_data_reg;
    logic [2*SAMPLE_BITS-1:0]      pend_data_reg;
    logic                          out_last_reg;

    logic [RATIO_BITS-1:0] tgt_c, sr_c;
    logic [GAIN_BITS-1:0]  gain_c;
    logic [RATIO_BITS-1:0] dmag;
    logic [DIFF_BITS-1:0]  mag_prod;
    logic signed [SAMPLE_BITS-1:0] il, ir;

    slr_div_ctrl_t div_ctrl;
    slr_div_stat_t div_stat;

    slr_divider u_div (.clk(clk), .rst_n(rst_n), .ctrl(div_ctrl), .stat(div_stat));

    // Interpolation: floor((a*ONE + t*(b-a)) / ONE), t below ONE.
    function automatic logic signed [SAMPLE_BITS-1:0] interp_f(
        input logic signed [SAMPLE_BITS-1:0] a,
        input logic signed [SAMPLE_BITS-1:0] b,
        input logic [FRAC_BITS-1:0]          t
    );
        logic signed [PROD_BITS-1:0] v;
        v = (PROD_BITS'(a) <<< FRAC_BITS)
            + $signed({1'b0, t}) * (PROD_BITS'(b) - PROD_BITS'(a));
        return v[FRAC_BITS +: SAMPLE_BITS];
    endfunction

    assign il = interp_f(prev_l_reg, cur_l_reg, phase_reg[FRAC_BITS-1:0]);
    assign ir = interp_f(prev_r_reg, cur_r_reg, phase_reg[FRAC_BITS-1:0]);

    // Ratio smoothing toward the clamped target; one multiply per output.
    always_comb
    begin
        tgt_c = target_reg;
        if (tgt_c < RATIO_MIN) tgt_c = RATIO_MIN;
        if (tgt_c > RATIO_MAX) tgt_c = RATIO_MAX;
        gain_c = (gain_reg > GAIN_BITS'(ONE_Q)) ? GAIN_BITS'(ONE_Q) : gain_reg;
        dmag = (tgt_c >= ratio_reg) ? tgt_c - ratio_reg : ratio_reg - tgt_c;
        mag_prod = DIFF_BITS'(dmag) * DIFF_BITS'(gain_c);
        if (tgt_c >= ratio_reg)
            sr_c = ratio_reg + mag_prod[FRAC_BITS +: RATIO_BITS];
        else
            sr_c = ratio_reg - mag_prod[FRAC_BITS +: RATIO_BITS];
    end

    // The interpolated frame waits in a staging register until the phase
    // step is known, since tlast depends on that step; it then moves into the
    // output register once the previous output has left.

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (s_tvalid && primed_reg)
                    state_next = (phase_reg < PHASE_BITS'(ONE_Q)) ? ST_EMIT : ST_FINISH;
            ST_EMIT:     state_next = ST_DIV;
            ST_DIV:
                if (div_stat.done)
                    state_next = ST_WAIT_OUT;
            ST_WAIT_OUT:
                if (!out_valid_reg || m_tready)
                    state_next = (phase_reg < PHASE_BITS'(ONE_Q)
                                  && cnt_reg != CNT_BITS'(MAX_OUT)) ? ST_EMIT : ST_FINISH;
            ST_FINISH:   state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready         = (state_reg == ST_IDLE);
        div_ctrl.start   = (state_reg == ST_EMIT);
        div_ctrl.divisor = (sr_c < RATIO_MIN) ? RATIO_MIN : sr_c;
        phase_next       = phase_reg;
        ratio_next       = ratio_reg;
        unique case (state_reg)
            ST_EMIT:   ratio_next = sr_c;
            ST_DIV:
                if (div_stat.done)
                    phase_next = phase_reg + PHASE_BITS'(div_stat.quotient);
            ST_FINISH:
                phase_next = (phase_reg >= PHASE_BITS'(ONE_Q))
                             ? phase_reg - PHASE_BITS'(ONE_Q) : '0;
            default: ;
        endcase
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tlast   = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            ratio_reg     <= ONE_Q;
            primed_reg    <= 1'b0;
            target_reg    <= ONE_Q;
            gain_reg      <= GAIN_BITS'(ONE_Q);
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            prev_l_reg    <= '0;
            prev_r_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            ratio_reg <= ratio_next;
            if (cfg_valid && cfg_index == REG_TARGET_RATIO)
                target_reg <= cfg_data;
            if (cfg_valid && cfg_index == REG_SMOOTH_GAIN)
                gain_reg <= cfg_data[GAIN_BITS-1:0];
            if (state_reg == ST_IDLE && s_tvalid)
            begin
                cnt_reg <= '0;
                if (!primed_reg)
                begin
                    primed_reg <= 1'b1;
                    prev_l_reg <= $signed(s_tdata[SAMPLE_BITS-1:0]);
                    prev_r_reg <= $signed(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
                end
            end
            if (state_reg == ST_EMIT)
                cnt_reg <= cnt_reg + 1'b1;
            if (state_reg == ST_WAIT_OUT && (!out_valid_reg || m_tready))
            begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= (phase_reg >= PHASE_BITS'(ONE_Q))
                                 || (cnt_reg == CNT_BITS'(MAX_OUT));
            end
            else if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_FINISH)
            begin
                prev_l_reg <= cur_l_reg;
                prev_r_reg <= cur_r_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            cur_l_reg <= $signed(s_tdata[SAMPLE_BITS-1:0]);
            cur_r_reg <= $signed(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
        end
        if (state_reg == ST_EMIT)
            pend_data_reg <= {ir, il};
        if (state_reg == ST_WAIT_OUT && (!out_valid_reg || m_tready))
            out_data_reg <= pend_data_reg;
    end

    // Assertions.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input accepted while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output changed while stalled");
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_BITS'(MAX_OUT))
        else $error("result count above cap");
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("divider finished outside divide state");

endmodule
